// ===== sv/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and state type of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;

    localparam logic [31:0] HEAP_BASE_RST = 32'd65536;
    localparam int          HEAP_SIZE_RST = 4096;

    // request kinds
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_REALLOC = 2'd2,
        KIND_CHECK   = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic {
        REG_HEAP_BASE = 1'b0,
        REG_HEAP_SIZE = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOC,
        S_F_CUR,
        S_F_N,
        S_F_NN,
        S_F_WCUR,
        S_F_DONE,
        S_A_START,
        S_A_LF,
        S_A_CUR,
        S_A_AFT,
        S_A_WCUR,
        S_OUT
    } t_state;

endpackage

// ===== sv/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a byte arena kept as a chain of block headers in
// one synchronous memory; free merges with free neighbors.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// request   in         i_valid / o_ready    i_kind, i_address, i_size
// result    out        o_valid / i_ready    o_result_address, o_ok
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// a request takes a data-dependent number of cycles: the first-fit walk visits
// one header per step and free runs a merge loop over the neighbors, both paced
// by the one read and one write per cycle of the header memory.
// reset and a size register write run a clearing pass over every entry of the
// header memory; no request is taken meanwhile.
// the result sits in an output register; the next request is taken while it
// waits, but a finished request stalls until the register is free.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ffa_pkg::t_kind      i_kind,
    input  logic [31:0]         i_address,
    input  logic [12:0]         i_size,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_result_address,
    output logic                o_ok,
    input  logic                i_cfg_we,
    input  ffa_pkg::t_reg       i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import ffa_pkg::*;

    localparam int OW = $clog2(HEAP_BYTES);
    localparam int RW = (OW + 2 > 15) ? OW + 2 : 15;
    localparam int RST_ARENA = (HEAP_SIZE_RST < HEAP_BYTES) ? HEAP_SIZE_RST : HEAP_BYTES;

    typedef struct packed {
        logic          live;
        logic          used;
        logic [OW-1:0] size;
        logic [OW-1:0] prev;
        logic          has_prev;
    } t_hdr;

    localparam logic [RW-1:0] HDR = RW'(HEADER_BYTES);

    t_hdr mem [HEAP_BYTES];

    t_state        r_state, n_state;
    logic [OW-1:0] r_clr, n_clr;
    logic [31:0]   r_base, n_base;
    logic [OW:0]   r_arena, n_arena;
    logic [OW-1:0] r_lf, n_lf;
    t_kind         r_kind, n_kind;
    logic [12:0]   r_req, n_req;
    logic [OW-1:0] r_cur, n_cur;
    logic [OW-1:0] r_n, n_n;
    logic [OW-1:0] r_aux, n_aux;
    logic [OW-1:0] r_nb, n_nb;
    t_hdr          r_ch, n_ch;
    logic          r_first, n_first;
    logic          r_res_ok, n_res_ok;
    logic [31:0]   r_res_addr, n_res_addr;
    logic          r_out_valid, n_out_valid;
    logic          r_out_ok, n_out_ok;
    logic [31:0]   r_out_addr, n_out_addr;
    t_hdr          r_rdata;

    logic          w_en;
    logic [OW-1:0] w_addr;
    t_hdr          w_data;
    logic          rd_en;
    logic [OW-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_base      <= HEAP_BASE_RST;
            r_arena     <= (OW+1)'(RST_ARENA);
            r_lf        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_base      <= n_base;
            r_arena     <= n_arena;
            r_lf        <= n_lf;
            r_out_valid <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_req      <= n_req;
        r_cur      <= n_cur;
        r_n        <= n_n;
        r_aux      <= n_aux;
        r_nb       <= n_nb;
        r_ch       <= n_ch;
        r_first    <= n_first;
        r_res_ok   <= n_res_ok;
        r_res_addr <= n_res_addr;
        r_out_ok   <= n_out_ok;
        r_out_addr <= n_out_addr;
    end

    always_comb begin
        t_hdr          h;
        t_hdr          fmt;
        logic [RW-1:0] nx;
        logic [RW-1:0] nn;
        logic [RW-1:0] nb;
        logic [OW-1:0] csel;
        logic [32:0]   lo;
        logic [32:0]   ofs;
        logic          loc_ok;
        logic [12:0]   hs;

        n_state     = r_state;
        n_clr       = r_clr;
        n_base      = r_base;
        n_arena     = r_arena;
        n_lf        = r_lf;
        n_kind      = r_kind;
        n_req       = r_req;
        n_cur       = r_cur;
        n_n         = r_n;
        n_aux       = r_aux;
        n_nb        = r_nb;
        n_ch        = r_ch;
        n_first     = r_first;
        n_res_ok    = r_res_ok;
        n_res_addr  = r_res_addr;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_addr  = r_out_addr;
        w_en        = 1'b0;
        w_addr      = '0;
        w_data      = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        h      = r_rdata;
        fmt    = '0;
        nx     = '0;
        nn     = '0;
        nb     = '0;
        csel   = '0;
        hs     = '0;
        lo     = {1'b0, r_base} + 33'(HEADER_BYTES);
        ofs    = {1'b0, i_address} - lo;
        loc_ok = (i_address != 32'd0) && ({1'b0, i_address} >= lo)
                 && (ofs < 33'(r_arena));

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // entry zero gets the single free block of a fresh arena
                if (r_clr == '0 && RW'(r_arena) >= HDR) begin
                    fmt.live = 1'b1;
                    fmt.size = OW'(RW'(r_arena) - HDR);
                end
                w_en   = 1'b1;
                w_addr = r_clr;
                w_data = fmt;
                if (r_clr == OW'(HEAP_BYTES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind     = i_kind;
                    n_req      = i_size;
                    n_res_ok   = 1'b0;
                    n_res_addr = '0;
                    n_cur      = ofs[OW-1:0];
                    n_first    = 1'b1;
                    rd_addr    = ofs[OW-1:0];
                    case (i_kind)
                        KIND_ALLOC: n_state = S_A_START;
                        KIND_CHECK: begin
                            rd_en   = loc_ok;
                            n_state = loc_ok ? S_LOC : S_OUT;
                        end
                        default: begin
                            if (i_kind == KIND_REALLOC && i_address == 32'd0) begin
                                n_state = S_A_START;
                            end else begin
                                rd_en   = loc_ok;
                                n_state = loc_ok ? S_F_CUR : S_OUT;
                            end
                        end
                    endcase
                end
            end
            S_LOC: begin
                n_res_ok = h.live;
                n_state  = S_OUT;
            end
            S_F_CUR: begin
                if (r_first && !h.live) begin
                    n_state = S_OUT;
                end else if (!r_first && !(h.live && !h.used)) begin
                    n_state = S_F_DONE;
                end else begin
                    csel      = r_first ? r_cur : r_aux;
                    n_cur     = csel;
                    n_ch      = h;
                    n_ch.used = 1'b0;
                    n_first   = 1'b0;
                    nx        = RW'(csel) + HDR + RW'(h.size);
                    if (nx < RW'(r_arena)) begin
                        rd_en   = 1'b1;
                        rd_addr = nx[OW-1:0];
                        n_n     = nx[OW-1:0];
                        n_state = S_F_N;
                    end else begin
                        n_state = S_F_WCUR;
                    end
                end
            end
            S_F_N: begin
                if (h.live && !h.used) begin
                    // absorb the free block after cur
                    n_ch.size = OW'(RW'(r_ch.size) + HDR + RW'(h.size));
                    w_en      = 1'b1;
                    w_addr    = r_n;
                    w_data    = '0;
                    nn        = RW'(r_n) + HDR + RW'(h.size);
                    if (nn < RW'(r_arena)) begin
                        rd_en   = 1'b1;
                        rd_addr = nn[OW-1:0];
                        n_aux   = nn[OW-1:0];
                        n_state = S_F_NN;
                    end else begin
                        n_state = S_F_WCUR;
                    end
                end else begin
                    n_state = S_F_WCUR;
                end
            end
            S_F_NN: begin
                if (h.live) begin
                    w_en            = 1'b1;
                    w_addr          = r_aux;
                    w_data          = h;
                    w_data.prev     = r_cur;
                    w_data.has_prev = 1'b1;
                end
                n_state = S_F_WCUR;
            end
            S_F_WCUR: begin
                w_en   = 1'b1;
                w_addr = r_cur;
                w_data = r_ch;
                // try the block before cur next
                if (r_ch.has_prev && r_ch.prev < r_cur
                        && RW'(r_ch.prev) < RW'(r_arena)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ch.prev;
                    n_aux   = r_ch.prev;
                    n_state = S_F_CUR;
                end else begin
                    n_state = S_F_DONE;
                end
            end
            S_F_DONE: begin
                if (r_cur < r_lf) begin
                    n_lf = r_cur;
                end
                if (r_kind == KIND_REALLOC) begin
                    n_state = S_A_START;
                end else begin
                    n_res_ok = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_A_START: begin
                if (r_req == '0) begin
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_lf;
                    n_state = S_A_LF;
                end
            end
            S_A_LF: begin
                // stale start point falls back to offset zero
                csel    = (RW'(r_lf) < RW'(r_arena) && h.live) ? r_lf : '0;
                n_cur   = csel;
                rd_en   = 1'b1;
                rd_addr = csel;
                n_state = S_A_CUR;
            end
            S_A_CUR: begin
                if (!h.live) begin
                    n_state = S_OUT;
                end else if (!h.used && RW'(h.size) >= RW'(r_req)) begin
                    n_res_ok   = 1'b1;
                    n_res_addr = r_base + 32'(r_cur) + 32'(HEADER_BYTES);
                    if (RW'(h.size) > RW'(r_req) + HDR) begin
                        nb              = RW'(r_cur) + HDR + RW'(r_req);
                        w_en            = 1'b1;
                        w_addr          = nb[OW-1:0];
                        w_data.live     = 1'b1;
                        w_data.used     = 1'b0;
                        w_data.size     = OW'(RW'(h.size) - RW'(r_req) - HDR);
                        w_data.prev     = r_cur;
                        w_data.has_prev = 1'b1;
                        n_ch            = h;
                        n_ch.size       = OW'(r_req);
                        n_ch.used       = 1'b1;
                        n_nb            = nb[OW-1:0];
                        if (r_lf == r_cur) begin
                            n_lf = nb[OW-1:0];
                        end
                        nx = RW'(r_cur) + HDR + RW'(h.size);
                        if (nx < RW'(r_arena)) begin
                            rd_en   = 1'b1;
                            rd_addr = nx[OW-1:0];
                            n_aux   = nx[OW-1:0];
                            n_state = S_A_AFT;
                        end else begin
                            n_state = S_A_WCUR;
                        end
                    end else begin
                        w_en        = 1'b1;
                        w_addr      = r_cur;
                        w_data      = h;
                        w_data.used = 1'b1;
                        n_state     = S_OUT;
                    end
                end else begin
                    nx = RW'(r_cur) + HDR + RW'(h.size);
                    if (nx < RW'(r_arena)) begin
                        rd_en   = 1'b1;
                        rd_addr = nx[OW-1:0];
                        n_cur   = nx[OW-1:0];
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_A_AFT: begin
                if (h.live) begin
                    w_en            = 1'b1;
                    w_addr          = r_aux;
                    w_data          = h;
                    w_data.prev     = r_nb;
                    w_data.has_prev = 1'b1;
                end
                n_state = S_A_WCUR;
            end
            S_A_WCUR: begin
                w_en    = 1'b1;
                w_addr  = r_cur;
                w_data  = r_ch;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_addr  = r_res_ok ? r_res_addr : 32'd0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            if (i_cfg_index == REG_HEAP_BASE) begin
                n_base = i_cfg_data;
            end else begin
                hs      = i_cfg_data[12:0];
                n_arena = (RW'(hs) < RW'(HEAP_BYTES)) ? (OW+1)'(hs) : (OW+1)'(HEAP_BYTES);
                n_lf    = '0;
                n_clr   = '0;
                n_state = S_CLEAR;
            end
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_ok             = r_out_ok;
    assign o_result_address = r_out_addr;

`ifndef SYNTHESIS
    a_take_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while another is in progress");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_result_address == 32'd0))
        else $error("failed word carries an address");

    a_lf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RW'(r_arena) >= HDR) |-> (RW'(r_lf) < RW'(r_arena)))
        else $error("search start outside the arena");
`endif

endmodule
